[design/adbp_pkg.sv]
// Shared constants and types for the audio DMA block pacer.
// No dependencies; every other design file imports this package.
`default_nettype none

package adbp_pkg;

	// Field widths of the channels.
	localparam int KIND_W     = 2;
	localparam int DELTA_W    = 17;
	localparam int DONE_W     = 3;
	localparam int LEN_W      = 20;
	localparam int START_W    = 29;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Defaults for the top-level parameters.
	localparam int MAX_BLOCKS_PER_TICK_DEF = 4;
	localparam int ACC_BITS_DEF            = 40;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 2'd2;

	localparam logic [CFG_DATA_W-1:0] START_MASK  = 32'h1fff_ffe0;
	localparam logic [CFG_DATA_W-1:0] LENGTH_MASK = 32'h000f_ffe0;

	// Time units: one byte lasts 125 units, one microsecond is 16 or 24 units.
	localparam int ADD_W                 = 22;
	localparam logic [ADD_W-1:0] UNITS_US_32K = 22'd16;
	localparam logic [ADD_W-1:0] UNITS_US_48K = 22'd24;

	// One block is length * 125 units, below 2^27.
	localparam int BLK_W                         = 27;
	localparam logic [BLK_W-1:0] UNITS_PER_BYTE  = 27'd125;

	// floor(x / 125) for x < 2^27 is (x * RECIP) >> RECIP_SHIFT, exact over that range.
	localparam int RECIP_W                   = 28;
	localparam int RECIP_SHIFT               = 34;
	localparam int PROD_W                    = BLK_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP     = 28'd137438954;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic sub_step;
		logic mul;
		logic fin;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic tick_active;
		logic sub_more;
	} dp_stat_t;

	typedef struct packed {
		logic [DONE_W-1:0]  blocks_done;
		logic [LEN_W-1:0]   bytes_left;
		logic [START_W-1:0] start_register;
		logic [LEN_W-1:0]   length_register;
		logic               dma_enabled;
		logic               rate_code;
	} result_t;

endpackage

`default_nettype wire

[design/adbp_if.sv]
// Channel interfaces of the audio DMA block pacer: input items, results and
// configuration writes. Depends on adbp_pkg for the field widths.
`default_nettype none

interface adbp_item_if
	import adbp_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [DELTA_W-1:0]  delta_us;

	modport source (output valid, kind, delta_us, input ready);
	modport sink (input valid, kind, delta_us, output ready);
endinterface

interface adbp_result_if
	import adbp_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [DONE_W-1:0]   blocks_done;
	logic [LEN_W-1:0]    bytes_left;
	logic [START_W-1:0]  start_register;
	logic [LEN_W-1:0]    length_register;
	logic                dma_enabled;
	logic                rate_code;

	modport source (output valid, blocks_done, bytes_left, start_register, length_register,
		dma_enabled, rate_code, input ready);
	modport sink (input valid, blocks_done, bytes_left, start_register, length_register,
		dma_enabled, rate_code, output ready);
endinterface

interface adbp_cfg_if
	import adbp_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/adbp_ctrl.sv]
// Sequencing state machine of the pacer: accepts an item, steps the datapath
// through its phases and hands the result to the output register. Uses adbp_pkg.
`default_nettype none

module adbp_ctrl
	import adbp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EXEC = 6'b000010,
		ST_SUB  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load_item = in_valid;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = (stat.is_tick && stat.tick_active) ? ST_SUB : ST_DONE;
			end
			ST_SUB: begin
				cmd.sub_step = 1'b1;
				if (!stat.sub_more) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// Wait here only while an earlier result is still unclaimed.
				cmd.load_out = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EXEC))
		else $error("accepted item did not enter execution");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

[design/adbp_dp.sv]
// Datapath of the pacer: configuration registers, time accumulator, block
// subtraction, divide-by-125 multiplier and result register. Uses adbp_pkg.
`default_nettype none

module adbp_dp
	import adbp_pkg::*;
#(
	parameter int MAX_BLOCKS_PER_TICK = MAX_BLOCKS_PER_TICK_DEF,
	parameter int ACC_BITS            = ACC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [KIND_W-1:0]     kind,
	input  wire logic [DELTA_W-1:0]    delta_us,
	input  wire dp_cmd_t               cmd,
	output dp_stat_t                   stat,
	output result_t                    result
);

	localparam int CNT_W = $clog2(MAX_BLOCKS_PER_TICK + 1);
	localparam int SUM_W = ACC_BITS + 1;

	// Architectural state.
	logic                 start_nz_q;
	logic [START_W-1:0]   shadow_q;
	logic [LEN_W-1:0]     len_q;
	logic                 rate_q;
	logic                 en_q;
	logic [ACC_BITS-1:0]  acc_q;
	logic [LEN_W-1:0]     bytes_q;

	// Per-item working registers.
	logic [KIND_W-1:0]    kind_q;
	logic [DELTA_W-1:0]   delta_q;
	logic [BLK_W-1:0]     block_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 lt_q;
	result_t              res_q;

	logic [ADD_W-1:0]     add_w;
	logic [SUM_W-1:0]     sum_w;
	logic [ACC_BITS-1:0]  block_ext;
	logic [LEN_W-1:0]     quot_w;
	logic [DONE_W-1:0]    done_w;

	assign add_w     = ADD_W'(delta_q) * (rate_q ? UNITS_US_48K : UNITS_US_32K);
	assign sum_w     = {1'b0, acc_q} + SUM_W'(add_w);
	assign block_ext = ACC_BITS'(block_q);
	assign quot_w    = prod_q[RECIP_SHIFT +: LEN_W];
	assign done_w    = (int'(cnt_q) > 7) ? 3'd7 : DONE_W'(cnt_q);

	assign stat.is_tick     = (kind_q == KIND_TICK);
	assign stat.tick_active = en_q && start_nz_q && (len_q != '0);
	assign stat.sub_more    = (cnt_q < CNT_W'(MAX_BLOCKS_PER_TICK)) && (acc_q >= block_ext);

	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_nz_q <= 1'b0;
			shadow_q   <= '0;
			len_q      <= '0;
			rate_q     <= 1'b0;
			en_q       <= 1'b0;
			acc_q      <= '0;
			bytes_q    <= '0;
			cnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_ADDR: begin
						start_nz_q <= (cfg_data != '0);
						shadow_q   <= START_W'(cfg_data & START_MASK);
					end
					CFG_LENGTH: begin
						len_q   <= LEN_W'(cfg_data & LENGTH_MASK);
						bytes_q <= LEN_W'(cfg_data & LENGTH_MASK);
					end
					CFG_RATE: begin
						rate_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.exec) begin
				cnt_q <= '0;
				case (kind_q)
					KIND_TICK: begin
						if (stat.tick_active) begin
							// Saturate at the accumulator width.
							acc_q <= sum_w[ACC_BITS] ? '1 : sum_w[ACC_BITS-1:0];
						end
					end
					KIND_START: begin
						en_q    <= 1'b1;
						bytes_q <= len_q;
					end
					KIND_STOP: begin
						en_q     <= 1'b0;
						shadow_q <= '0;
						bytes_q  <= '0;
						acc_q    <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.sub_step && stat.sub_more) begin
				acc_q <= acc_q - block_ext;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.fin) begin
				bytes_q <= lt_q ? (len_q - quot_w) : len_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= kind;
			delta_q <= delta_us;
		end
		if (cmd.exec) begin
			block_q <= BLK_W'(len_q) * UNITS_PER_BYTE;
		end
		if (cmd.mul) begin
			// The quotient is only used when the accumulator is below one block.
			prod_q <= PROD_W'(acc_q[BLK_W-1:0]) * PROD_W'(RECIP);
			lt_q   <= (acc_q < block_ext);
		end
		if (cmd.load_out) begin
			res_q.blocks_done     <= done_w;
			res_q.bytes_left      <= bytes_q;
			res_q.start_register  <= shadow_q;
			res_q.length_register <= len_q;
			res_q.dma_enabled     <= en_q;
			res_q.rate_code       <= rate_q;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAX_BLOCKS_PER_TICK)
		else $error("block count beyond the per-tick cap");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && lt_q) |-> (quot_w <= len_q))
		else $error("remaining-time quotient exceeds the block length");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && kind_q == KIND_STOP && !cfg_we) |=> (acc_q == '0 && !en_q))
		else $error("stop left the accumulator or enable set");

endmodule

`default_nettype wire

[design/audio_dma_block_pacer.sv]
// Audio DMA block pacer, top level. Joins the controller and the datapath and
// maps them onto the channel interfaces. Uses adbp_pkg, adbp_if, adbp_ctrl, adbp_dp.
//
// Usage:
//   items   : kind (tick, start, stop) and delta_us; each item yields one result.
//   results : blocks completed, bytes left in the current block, register views,
//             enable flag and rate code.
//   cfg     : register writes (0 start address, 1 length, 2 rate select); always
//             ready; user must write only while no item is in flight (unenforced).
// Steps from the accepted item to the loaded result:
//   start, stop, unused kind or a tick while pacing is off: execution, result load.
//   a pacing tick: execution, the block subtraction loop, one block per cycle and at
//   most MAX_BLOCKS_PER_TICK blocks, the divide-by-125 multiplier, the bytes-left
//   update, then the result load.
//   One item is worked on at a time; the next is accepted the cycle after the
//   result register is loaded.
// Output: a single result register. While the receiver stalls, the next item is
//   still accepted and processed, and it waits before loading until the held
//   result is taken.
// Reset clears config registers, accumulator and enable flag; no result is valid.
`default_nettype none

module audio_dma_block_pacer
	import adbp_pkg::*;
#(
	parameter int MAX_BLOCKS_PER_TICK = MAX_BLOCKS_PER_TICK_DEF,
	parameter int ACC_BITS            = ACC_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	adbp_item_if.sink      items,
	adbp_result_if.source  results,
	adbp_cfg_if.sink       cfg
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	result_t  result;

	assign cfg.ready = 1'b1;

	adbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	adbp_dp #(
		.MAX_BLOCKS_PER_TICK (MAX_BLOCKS_PER_TICK),
		.ACC_BITS            (ACC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.kind      (items.kind),
		.delta_us  (items.delta_us),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

	assign results.blocks_done     = result.blocks_done;
	assign results.bytes_left      = result.bytes_left;
	assign results.start_register  = result.start_register;
	assign results.length_register = result.length_register;
	assign results.dma_enabled     = result.dma_enabled;
	assign results.rate_code       = result.rate_code;

endmodule

`default_nettype wire

[tb/tb_audio_dma_block_pacer.sv]
// Self-checking testbench for the audio DMA block pacer: directed and random
// items with random idling on both channels. Needs adbp_pkg, adbp_if and the design.
`timescale 1ns / 1ps

// Tracks the pacer's registers and time accumulator and holds the results due.
class pacer_scoreboard #(int ACC_W = 40, int BLOCK_CAP = 4);
	logic [31:0] start_raw;
	logic [31:0] length_raw;
	logic        rate_sel;
	logic        enabled;
	logic [63:0] acc;
	logic [19:0] bytes_left;
	logic [28:0] start_view;
	int          mismatches;
	int          checked;
	adbp_pkg::result_t due_q[$];

	function new();
		start_raw  = '0;
		length_raw = '0;
		rate_sel   = 1'b0;
		enabled    = 1'b0;
		acc        = '0;
		bytes_left = '0;
		start_view = '0;
		mismatches = 0;
		checked    = 0;
	endfunction

	function logic [19:0] length_bytes();
		logic [31:0] m;
		m = length_raw & adbp_pkg::LENGTH_MASK;
		return m[19:0];
	endfunction

	function int pending();
		return due_q.size();
	endfunction

	function void write_reg(logic [adbp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		logic [31:0] m;
		m = val & adbp_pkg::START_MASK;
		case (idx)
			adbp_pkg::CFG_START_ADDR: begin
				start_raw  = val;
				start_view = m[28:0];
			end
			adbp_pkg::CFG_LENGTH: begin
				length_raw = val;
				bytes_left = length_bytes();
			end
			adbp_pkg::CFG_RATE: rate_sel = val[0];
			default: ;
		endcase
	endfunction

	// One byte lasts 125 units; a microsecond is 16 units at 32 kHz, 24 at 48 kHz.
	function logic [2:0] advance_time(logic [16:0] delta);
		logic [63:0] top;
		logic [63:0] add;
		logic [63:0] blk;
		logic [19:0] len;
		int          done;
		len  = length_bytes();
		done = 0;
		if (!enabled || start_raw == 0 || len == 0)
			return 3'd0;
		top = (ACC_W >= 64) ? '1 : (64'd1 << ACC_W) - 64'd1;
		add = 64'(delta) * (rate_sel ? 64'd24 : 64'd16);
		if (acc > top || add > top - acc)
			acc = top;
		else
			acc = acc + add;
		blk = 64'(len) * 64'd125;
		while (done < BLOCK_CAP && acc >= blk) begin
			acc        = acc - blk;
			bytes_left = len;
			done++;
		end
		if (acc < blk)
			bytes_left = len - 20'(acc / 64'd125);
		return (done > 7) ? 3'd7 : 3'(done);
	endfunction

	function void note_item(logic [adbp_pkg::KIND_W-1:0] kind, logic [16:0] delta);
		adbp_pkg::result_t exp;
		logic [2:0]        done;
		done = 3'd0;
		case (kind)
			adbp_pkg::KIND_TICK: done = advance_time(delta);
			adbp_pkg::KIND_START: begin
				enabled    = 1'b1;
				bytes_left = length_bytes();
			end
			adbp_pkg::KIND_STOP: begin
				enabled    = 1'b0;
				start_view = '0;
				bytes_left = '0;
				acc        = '0;
			end
			default: ;
		endcase
		exp.blocks_done     = done;
		exp.bytes_left      = bytes_left;
		exp.start_register  = start_view;
		exp.length_register = length_bytes();
		exp.dma_enabled     = enabled;
		exp.rate_code       = rate_sel;
		due_q.push_back(exp);
	endfunction

	function void check_result(adbp_pkg::result_t got);
		adbp_pkg::result_t exp;
		checked++;
		if (due_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d arrived with nothing expected: done=%0d left=%0d",
					checked, got.blocks_done, got.bytes_left);
			return;
		end
		exp = due_q.pop_front();
		if (got.blocks_done !== exp.blocks_done || got.bytes_left !== exp.bytes_left ||
				got.start_register !== exp.start_register ||
				got.length_register !== exp.length_register ||
				got.dma_enabled !== exp.dma_enabled || got.rate_code !== exp.rate_code) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display({"result %0d mismatch: expected done=%0d left=%0d start=%h len=%0d",
					" en=%0b rate=%0b"}, checked, exp.blocks_done, exp.bytes_left,
					exp.start_register, exp.length_register, exp.dma_enabled,
					exp.rate_code);
				$display("  actual done=%0d left=%0d start=%h len=%0d en=%0b rate=%0b",
					got.blocks_done, got.bytes_left, got.start_register,
					got.length_register, got.dma_enabled, got.rate_code);
			end
		end
	endfunction
endclass

module tb_audio_dma_block_pacer
	import adbp_pkg::*;
();
	// A 32-bit accumulator, narrower than the default of 40 bits.
	localparam int ACC_W      = 32;
	localparam int STUCK_MAX  = 4000;
	localparam int PHASES     = 12;
	localparam int PHASE_LEN  = 70;
	localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE    = 2'd3;
	localparam logic [DELTA_W-1:0]   DELTA_MAX   = 17'h1ffff;

	logic clk;
	logic arst_n;
	bit   quiet_run;
	int   stuck_cycles;
	result_t result_seen;

	adbp_item_if   item_ch();
	adbp_result_if result_ch();
	adbp_cfg_if    cfg_ch();

	pacer_scoreboard #(ACC_W, MAX_BLOCKS_PER_TICK_DEF) sb;

	audio_dma_block_pacer #(.ACC_BITS(ACC_W)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			result_seen.blocks_done     = result_ch.blocks_done;
			result_seen.bytes_left      = result_ch.bytes_left;
			result_seen.start_register  = result_ch.start_register;
			result_seen.length_register = result_ch.length_register;
			result_seen.dma_enabled     = result_ch.dma_enabled;
			result_seen.rate_code       = result_ch.rate_code;
			sb.check_result(result_seen);
		end
		result_ch.ready <= quiet_run || ($urandom_range(0, 99) >= 16);
	end

	// Any accepted item, result or register write counts as progress.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_MAX) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [DELTA_W-1:0] delta);
		if (!quiet_run) begin
			while ($urandom_range(0, 99) < 16) begin
				item_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_ch.valid    <= 1'b1;
		item_ch.kind     <= kind;
		item_ch.delta_us <= delta;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sb.note_item(kind, delta);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_config(input logic [31:0] start_val, input logic [31:0] len_val,
			input logic rate_val, input bit poke_unused);
		write_reg(CFG_START_ADDR, start_val);
		write_reg(CFG_LENGTH, len_val);
		write_reg(CFG_RATE, ($urandom & ~32'd1) | 32'(rate_val));
		if (poke_unused)
			write_reg(CFG_NONE, $urandom);
		cfg_ch.valid <= 1'b0;
	endtask

	// Holds the sender off until every result due has been taken.
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DELTA_W-1:0] pick_delta();
		logic [63:0] span;
		logic [19:0] len;
		int          r;
		r   = $urandom_range(0, 99);
		len = sb.length_bytes();
		if (r < 5)
			return '0;
		if (r < 25 || len == 0)
			return DELTA_W'($urandom_range(0, 131071));
		// Up to about five blocks' worth, so the per-tick cap is hit now and then.
		span = (64'(len) * 64'd625) / (sb.rate_sel ? 64'd24 : 64'd16);
		if (span > 64'd131071)
			span = 64'd131071;
		return DELTA_W'($urandom_range(0, 32'(span)));
	endfunction

	function automatic logic [31:0] pick_length();
		logic [31:0] bytes;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 4)
			bytes = '0;
		else if (r < 9)
			bytes = LENGTH_MASK;
		else if (r < 60)
			bytes = 32'($urandom_range(1, 48)) << 5;
		else if (r < 85)
			bytes = 32'($urandom_range(1, 2047)) << 5;
		else
			bytes = $urandom;
		return ($urandom & ~LENGTH_MASK) | (bytes & LENGTH_MASK);
	endfunction

	function automatic logic [31:0] pick_start();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return '0;
		if (r < 12)
			return $urandom & ~START_MASK;
		if (r < 18)
			return 32'hffff_ffff;
		return $urandom;
	endfunction

	task automatic run_random_phase(input int phase);
		logic rate_val;
		int   r;
		rate_val = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
		drain();
		set_config(pick_start(), pick_length(), rate_val, $urandom_range(0, 3) == 0);
		send_item(KIND_START, DELTA_W'($urandom));
		repeat (PHASE_LEN - 1) begin
			r = $urandom_range(0, 99);
			if (r < 82)
				send_item(KIND_TICK, pick_delta());
			else if (r < 89)
				send_item(KIND_START, DELTA_W'($urandom));
			else if (r < 95)
				send_item(KIND_STOP, DELTA_W'($urandom));
			else
				send_item(KIND_UNUSED, DELTA_W'($urandom));
		end
	endtask

	initial begin
		sb               = new();
		quiet_run        = 1'b0;
		stuck_cycles     = 0;
		arst_n           = 1'b0;
		item_ch.valid    = 1'b0;
		item_ch.kind     = KIND_TICK;
		item_ch.delta_us = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = CFG_START_ADDR;
		cfg_ch.data      = '0;
		result_ch.ready  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Shortest block: ticks before start, exact block boundary, cap, unused kind.
		set_config(32'h1fff_ffe0, 32'h0000_0020, 1'b0, 1'b0);
		send_item(KIND_TICK, 17'd5);
		send_item(KIND_START, DELTA_MAX);
		send_item(KIND_TICK, 17'd0);
		send_item(KIND_TICK, 17'd250);
		send_item(KIND_TICK, 17'd249);
		send_item(KIND_TICK, DELTA_MAX);
		send_item(KIND_UNUSED, DELTA_MAX);
		send_item(KIND_STOP, 17'd0);
		send_item(KIND_TICK, 17'd100);
		// After a stop the start view reads zero, yet the raw address still allows pacing.
		send_item(KIND_START, 17'd0);
		send_item(KIND_TICK, 17'd1000);

		// Zero start address keeps an enabled pacer idle; longest block at 48 kHz.
		drain();
		set_config(32'h0000_0000, 32'hffff_ffff, 1'b1, 1'b1);
		send_item(KIND_START, 17'd0);
		send_item(KIND_TICK, DELTA_MAX);
		drain();
		set_config(32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
		send_item(KIND_TICK, DELTA_MAX);
		send_item(KIND_TICK, 17'd0);
		send_item(KIND_TICK, DELTA_MAX);

		// Raw values that mask to zero: the length blocks pacing, the address does not.
		drain();
		set_config(32'h0000_001f, 32'h0000_001f, 1'b0, 1'b0);
		send_item(KIND_TICK, DELTA_MAX);
		send_item(KIND_START, 17'd3);
		send_item(KIND_TICK, 17'd7);
		send_item(KIND_STOP, DELTA_MAX);
		send_item(KIND_UNUSED, 17'd0);

		// Full ticks on the shortest block, each one held to the per-tick block cap.
		drain();
		set_config(32'h0000_0040, 32'h0000_0020, 1'b1, 1'b0);
		send_item(KIND_START, 17'd0);
		repeat (20)
			send_item(KIND_TICK, DELTA_MAX);
		send_item(KIND_STOP, 17'd0);

		for (int p = 0; p < PHASES; p++) begin
			quiet_run <= (p == 5);
			run_random_phase(p);
		end

		drain();
		quiet_run <= 1'b0;
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[files.f]
design/adbp_pkg.sv
design/adbp_if.sv
design/adbp_ctrl.sv
design/adbp_dp.sv
design/audio_dma_block_pacer.sv
tb/tb_audio_dma_block_pacer.sv
